### rtl/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg
// Shared types and constants for the polygon column span fill block.
// ----------------------------------------------------------------------------
package pcsf_pkg;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int VIDX_W   = 4;
  localparam int X_W      = 11;
  localparam int Y_W      = 10;
  localparam int VCOUNT_W = 5;

  // Vertex table limits and register reset
  localparam int MAX_VERTICES_DEF = 16;
  localparam int MIN_VERTICES     = 3;
  localparam int VCOUNT_RESET     = 6;

  // Interpolation datapath: product, remainder and quotient widths
  localparam int PROD_W    = X_W + Y_W;     // y * dx fits here
  localparam int REM_W     = PROD_W + 1;    // 2 * sum + dx
  localparam int DIV_STEPS = Y_W;           // quotient bits

  // Item codes
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_NEXT  = 2'd2
  } mode_t;

endpackage

### rtl/pcsf_if.sv
// ----------------------------------------------------------------------------
// pcsf_if
// Valid/ready channels of the polygon column span fill block: command items
// in, column spans out.
// ----------------------------------------------------------------------------
interface pcsf_cmd_if import pcsf_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [VIDX_W-1:0] vertex_index;
  logic [X_W-1:0]    vertex_x;
  logic [Y_W-1:0]    vertex_y;

  modport source (output valid, mode, vertex_index, vertex_x, vertex_y, input ready);
  modport sink   (input valid, mode, vertex_index, vertex_x, vertex_y, output ready);
endinterface

interface pcsf_span_if import pcsf_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [X_W-1:0] column_x;
  logic [Y_W-1:0] end_a_y;
  logic [Y_W-1:0] end_b_y;
  logic           last_column;

  modport source (output valid, column_x, end_a_y, end_b_y, last_column, input ready);
  modport sink   (input valid, column_x, end_a_y, end_b_y, last_column, output ready);
endinterface

### rtl/polygon_column_span_fill_top.sv
// A next transaction walks the forward and backward chain pointers and interpolates y on
// each chain in turn through the one-read vertex table and the shared multiplier / 10-step
// divider; a chain clamped to an edge end skips the multiplier and the divider.
// Throughput: one transaction at a time; ready is high only while idle.
// Reset (rst, synchronous): idle, no fill active, vertex_count = 6, table undefined.
// ----------------------------------------------------------------------------
// polygon_column_span_fill_top
// Column-by-column fill of an x-monotone polygon. Vertices are loaded into a
// small table, a start scans it for min/max x, and each next transaction walks
// both chain pointers and interpolates y on both chains with half-up rounding.
// ----------------------------------------------------------------------------
module polygon_column_span_fill_top import pcsf_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [VCOUNT_W-1:0] cfg_wr_data,
  pcsf_cmd_if.sink            cmd,
  pcsf_span_if.source         span
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = IW + 1;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SCAN_RD  = 12'b000000000010,
    S_SCAN_CMP = 12'b000000000100,
    S_WALK_RD  = 12'b000000001000,
    S_WALK_CMP = 12'b000000010000,
    S_EDGE_RD0 = 12'b000000100000,
    S_EDGE_RD1 = 12'b000001000000,
    S_EDGE_CHK = 12'b000010000000,
    S_MUL0     = 12'b000100000000,
    S_MUL1     = 12'b001000000000,
    S_DIV      = 12'b010000000000,
    S_FIN      = 12'b100000000000
  } state_t;

  // Finished column waiting for the output register
  state_t state;
  logic   emit_pend;

  // Control and walk state
  logic [VCOUNT_W-1:0] vcount;
  logic [X_W-1:0]      x_cur;
  logic [X_W-1:0]      x_end;
  logic [IW-1:0]       fwd_idx;
  logic [IW-1:0]       bwd_idx;
  logic                active;
  logic                dir;
  logic [IW-1:0]       work_idx;
  logic [CW-1:0]       steps;

  // Edge and arithmetic registers
  logic [X_W-1:0]    xa;
  logic [Y_W-1:0]    ya;
  logic [Y_W-1:0]    yb;
  logic [X_W-1:0]    dx;
  logic [X_W-1:0]    t;
  logic [PROD_W-1:0] acc;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  div_d;
  logic [Y_W-1:0]    quot;
  logic [3:0]        bitcnt;
  logic [Y_W-1:0]    y_a;

  // Output register
  logic           out_valid;
  logic [X_W-1:0] out_x;
  logic [Y_W-1:0] out_a;
  logic [Y_W-1:0] out_b;
  logic           out_last;

  // Vertex table
  logic [X_W-1:0] mem_x [MAX_VERTICES];
  logic [Y_W-1:0] mem_y [MAX_VERTICES];
  logic [X_W-1:0] rd_x;
  logic [Y_W-1:0] rd_y;
  logic [IW-1:0]  rd_addr;
  logic           mem_we;

  logic            acc_in;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   idx_inc;
  logic [IW-1:0]   nx_fwd;
  logic [IW-1:0]   nx_bwd;
  logic [IW-1:0]   nx;
  logic [IW-1:0]   fwd_start;
  logic [IW-1:0]   bwd_start;
  logic            scan_first;
  logic [X_W-1:0]  lo_next;
  logic [X_W-1:0]  hi_next;
  logic [IW-1:0]   lo_i_next;
  logic [Y_W-1:0]  mul_a;
  logic [X_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sum;
  logic              div_take;
  logic [Y_W-1:0]    quot_next;
  logic [X_W:0]      x_inc;

  assign cmd.ready = (state == S_IDLE) && !emit_pend;
  assign acc_in    = cmd.valid && cmd.ready;

  // Vertex count in use, clamped to the table range
  always_comb begin
    if (vcount < VCOUNT_W'(MIN_VERTICES)) begin
      cnt = CW'(MIN_VERTICES);
    end else if (int'(vcount) > MAX_VERTICES) begin
      cnt = CW'(MAX_VERTICES);
    end else begin
      cnt = CW'(vcount);
    end
  end

  // Cyclic neighbors of the working index
  always_comb begin
    cnt_m1  = cnt - CW'(1);
    idx_inc = {1'b0, work_idx} + CW'(1);
    nx_fwd  = (idx_inc >= cnt) ? '0 : idx_inc[IW-1:0];
    nx_bwd  = (work_idx == '0) ? cnt_m1[IW-1:0] : work_idx - IW'(1);
    nx      = dir ? nx_bwd : nx_fwd;
    fwd_start = ({1'b0, fwd_idx} >= cnt) ? '0 : fwd_idx;
    bwd_start = ({1'b0, bwd_idx} >= cnt) ? '0 : bwd_idx;
  end

  // Running min/max for the start scan
  always_comb begin
    scan_first = (work_idx == '0);
    lo_next    = x_cur;
    hi_next    = x_end;
    lo_i_next  = fwd_idx;
    if (scan_first || rd_x < x_cur) begin
      lo_next   = rd_x;
      lo_i_next = work_idx;
    end
    if (scan_first || rd_x > x_end) begin
      hi_next = rd_x;
    end
  end

  // Table read address
  always_comb begin
    case (state)
      S_WALK_RD:  rd_addr = nx;
      S_EDGE_RD1: rd_addr = nx;
      default:    rd_addr = work_idx;
    endcase
  end

  assign mem_we = acc_in && (cmd.mode == MODE_LOAD) &&
                  (int'(cmd.vertex_index) < MAX_VERTICES);

  // Vertex table: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[IW'(cmd.vertex_index)] <= cmd.vertex_x;
      mem_y[IW'(cmd.vertex_index)] <= cmd.vertex_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // Shared multiplier and divider step
  always_comb begin
    mul_a     = (state == S_MUL0) ? ya : yb;
    mul_b     = (state == S_MUL0) ? (dx - t) : t;
    prod      = PROD_W'({{X_W{1'b0}}, mul_a} * {{Y_W{1'b0}}, mul_b});
    sum       = acc + prod;
    div_take  = (rem >= div_d);
    quot_next = {quot[Y_W-2:0], div_take};
    x_inc     = {1'b0, x_cur} + (X_W+1)'(1);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_W'(VCOUNT_RESET);
    end else if (cfg_wr_en) begin
      vcount <= cfg_wr_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_pend <= 1'b0;
      active    <= 1'b0;
      x_cur     <= '0;
      x_end     <= '0;
      fwd_idx   <= '0;
      bwd_idx   <= '0;
      out_valid <= 1'b0;
      dir       <= 1'b0;
      work_idx  <= '0;
      steps     <= '0;
    end else begin
      // Finished column waits here until the output register frees up
      if (emit_pend && (!out_valid || span.ready)) begin
        out_valid <= 1'b1;
        out_x     <= x_cur;
        out_a     <= y_a;
        out_b     <= quot;
        out_last  <= (x_inc == {1'b0, x_end});
        x_cur     <= x_inc[X_W-1:0];
        if (x_inc[X_W-1:0] >= x_end) begin
          active <= 1'b0;
        end
        emit_pend <= 1'b0;
      end else if (span.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (acc_in) begin
            case (cmd.mode)
              MODE_START: begin
                work_idx <= '0;
                state    <= S_SCAN_RD;
              end
              MODE_NEXT: begin
                if (active) begin
                  dir      <= 1'b0;
                  work_idx <= fwd_start;
                  steps    <= '0;
                  state    <= S_WALK_RD;
                end
              end
              default: ;
            endcase
          end
        end

        S_SCAN_RD: state <= S_SCAN_CMP;

        S_SCAN_CMP: begin
          x_cur   <= lo_next;
          x_end   <= hi_next;
          fwd_idx <= lo_i_next;
          if (idx_inc == cnt) begin
            bwd_idx <= lo_i_next;
            active  <= (lo_next < hi_next);
            state   <= S_IDLE;
          end else begin
            work_idx <= idx_inc[IW-1:0];
            state    <= S_SCAN_RD;
          end
        end

        // Advance the pointer while the next vertex x is at most the column
        S_WALK_RD: begin
          state <= (steps == cnt) ? S_EDGE_RD0 : S_WALK_CMP;
        end

        S_WALK_CMP: begin
          if (rd_x > x_cur) begin
            state <= S_EDGE_RD0;
          end else begin
            work_idx <= nx;
            steps    <= steps + CW'(1);
            state    <= S_WALK_RD;
          end
        end

        S_EDGE_RD0: begin
          if (dir) begin
            bwd_idx <= work_idx;
          end else begin
            fwd_idx <= work_idx;
          end
          state <= S_EDGE_RD1;
        end

        S_EDGE_RD1: begin
          xa    <= rd_x;
          ya    <= rd_y;
          state <= S_EDGE_CHK;
        end

        // Clamp outside the edge, else set up the interpolation
        S_EDGE_CHK: begin
          if (x_cur <= xa) begin
            quot  <= ya;
            state <= S_FIN;
          end else if (x_cur >= rd_x) begin
            quot  <= rd_y;
            state <= S_FIN;
          end else begin
            yb    <= rd_y;
            dx    <= rd_x - xa;
            t     <= x_cur - xa;
            state <= S_MUL0;
          end
        end

        S_MUL0: begin
          acc   <= prod;
          state <= S_MUL1;
        end

        // Numerator 2*(ya*(dx-t) + yb*t) + dx over 2*dx
        S_MUL1: begin
          rem    <= {sum, 1'b0} + REM_W'(dx);
          div_d  <= {1'b0, dx, {DIV_STEPS{1'b0}}};
          quot   <= '0;
          bitcnt <= '0;
          state  <= S_DIV;
        end

        S_DIV: begin
          if (div_take) begin
            rem <= rem - div_d;
          end
          div_d  <= div_d >> 1;
          quot   <= quot_next;
          bitcnt <= bitcnt + 4'd1;
          if (bitcnt == 4'(DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (!dir) begin
            y_a      <= quot;
            dir      <= 1'b1;
            work_idx <= bwd_start;
            steps    <= '0;
            state    <= S_WALK_RD;
          end else begin
            emit_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign span.valid       = out_valid;
  assign span.column_x    = out_x;
  assign span.end_a_y     = out_a;
  assign span.end_b_y     = out_b;
  assign span.last_column = out_last;

  // A span only appears when a finished column is pending
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit_pend))
    else $error("span valid without a finished column");

  // The fill ends only at a column hand-off or a start scan
  assert property (@(posedge clk) disable iff (rst)
    $fell(active) |-> ($past(emit_pend) || $past(state == S_SCAN_CMP)))
    else $error("fill cleared outside emit or start");

  // Restoring divider keeps its partial remainder below twice the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem} < {div_d, 1'b0}))
    else $error("divider remainder out of range");

endmodule

### verif/pcsf_span_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcsf_span_checker
// Watches the command and span channels of the polygon column span fill
// block. It keeps its own vertex table, fill state and vertex count, works
// out the span that each accepted next transaction must produce, and
// compares every accepted span field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module pcsf_span_checker import pcsf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [VCOUNT_W-1:0] cfg_wr_data,
  pcsf_cmd_if                 cmd,
  pcsf_span_if                span,
  output int                  fail_count,
  output int                  spans_pending
);

  localparam int NVERT = MAX_VERTICES_DEF;

  typedef struct packed {
    logic [X_W-1:0] column_x;
    logic [Y_W-1:0] end_a_y;
    logic [Y_W-1:0] end_b_y;
    logic           last_column;
  } span_t;

  // Mirror of the block state
  logic [X_W-1:0]      vert_x [NVERT];
  logic [Y_W-1:0]      vert_y [NVERT];
  logic [X_W-1:0]      col_now;
  logic [X_W-1:0]      col_end;
  int unsigned         fwd_ptr;
  int unsigned         bwd_ptr;
  logic                filling;
  logic [VCOUNT_W-1:0] vcount;

  // Spans still owed by the block, oldest first
  span_t span_q[$];

  // Vertex count as the block uses it, clamped to the table
  function automatic int unsigned active_count();
    int unsigned c;
    c = vcount;
    if (c < MIN_VERTICES) c = MIN_VERTICES;
    if (c > NVERT) c = NVERT;
    return c;
  endfunction

  // Cyclic neighbor along one chain
  function automatic int unsigned neighbor(int unsigned idx, bit fwd, int unsigned cnt);
    if (fwd) return (idx + 1 >= cnt) ? 0 : idx + 1;
    return (idx == 0) ? cnt - 1 : idx - 1;
  endfunction

  // Move a chain pointer while its next vertex is not past column x
  function automatic int unsigned advance_ptr(int unsigned idx, bit fwd,
                                              logic [X_W-1:0] x, int unsigned cnt);
    int unsigned p;
    int unsigned nx;
    p = (idx >= cnt) ? 0 : idx;
    for (int unsigned s = 0; s < cnt; s++) begin
      nx = neighbor(p, fwd, cnt);
      if (vert_x[nx] > x) break;
      p = nx;
    end
    return p;
  endfunction

  // y on the edge leaving idx, rounded half up; clamped to the edge ends
  function automatic logic [Y_W-1:0] chain_y(int unsigned idx, bit fwd,
                                             logic [X_W-1:0] x, int unsigned cnt);
    int unsigned     nx;
    longint unsigned xa, xb, ya, yb, dx, t, num;
    nx = neighbor(idx, fwd, cnt);
    xa = vert_x[idx];
    ya = vert_y[idx];
    xb = vert_x[nx];
    yb = vert_y[nx];
    if (x <= xa) return Y_W'(ya);
    if (x >= xb) return Y_W'(yb);
    dx  = xb - xa;
    t   = x - xa;
    num = 2 * (ya * (dx - t) + yb * t) + dx;
    return Y_W'(num / (2 * dx));
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Predict on commands, compare on spans
  always @(posedge clk) begin : monitor
    span_t          got;
    span_t          want;
    int unsigned    cnt;
    int unsigned    lo_i;
    logic [X_W-1:0] lo;
    logic [X_W-1:0] hi;
    logic [X_W-1:0] x;
    if (rst) begin
      for (int i = 0; i < NVERT; i++) begin
        vert_x[i] = '0;
        vert_y[i] = '0;
      end
      col_now    = '0;
      col_end    = '0;
      fwd_ptr    = 0;
      bwd_ptr    = 0;
      filling    = 1'b0;
      vcount     = VCOUNT_W'(VCOUNT_RESET);
      fail_count = 0;
      span_q.delete();
    end else begin
      if (cfg_wr_en) vcount = cfg_wr_data;

      // Span transaction against the oldest expectation
      if (span.valid && span.ready) begin
        got = '{column_x: span.column_x, end_a_y: span.end_a_y,
                end_b_y: span.end_b_y, last_column: span.last_column};
        if (span_q.size() == 0) begin
          fail_count++;
          $display("%0t: span mismatch: expected none, actual x=%0d a=%0d b=%0d last=%0b",
                   $time, got.column_x, got.end_a_y, got.end_b_y, got.last_column);
        end else begin
          want = span_q.pop_front();
          if (got.column_x !== want.column_x)
            flag_field("column_x", 32'(want.column_x), 32'(got.column_x));
          if (got.end_a_y !== want.end_a_y)
            flag_field("end_a_y", 32'(want.end_a_y), 32'(got.end_a_y));
          if (got.end_b_y !== want.end_b_y)
            flag_field("end_b_y", 32'(want.end_b_y), 32'(got.end_b_y));
          if (got.last_column !== want.last_column)
            flag_field("last_column", 32'(want.last_column), 32'(got.last_column));
        end
      end

      // Command transaction updates the mirrored state
      if (cmd.valid && cmd.ready) begin
        cnt = active_count();
        case (cmd.mode)
          MODE_LOAD: begin
            vert_x[cmd.vertex_index] = cmd.vertex_x;
            vert_y[cmd.vertex_index] = cmd.vertex_y;
          end
          MODE_START: begin
            lo   = vert_x[0];
            hi   = vert_x[0];
            lo_i = 0;
            for (int unsigned i = 1; i < cnt; i++) begin
              if (vert_x[i] < lo) begin
                lo   = vert_x[i];
                lo_i = i;
              end
              if (vert_x[i] > hi) hi = vert_x[i];
            end
            col_now = lo;
            col_end = hi;
            fwd_ptr = lo_i;
            bwd_ptr = lo_i;
            filling = lo < hi;
          end
          MODE_NEXT: begin
            if (filling) begin
              x       = col_now;
              fwd_ptr = advance_ptr(fwd_ptr, 1'b1, x, cnt);
              bwd_ptr = advance_ptr(bwd_ptr, 1'b0, x, cnt);
              want.column_x    = x;
              want.end_a_y     = chain_y(fwd_ptr, 1'b1, x, cnt);
              want.end_b_y     = chain_y(bwd_ptr, 1'b0, x, cnt);
              want.last_column = (int'(x) + 1 == int'(col_end));
              span_q.push_back(want);
              col_now = x + 1'b1;
              if (col_now >= col_end) filling = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
    spans_pending = span_q.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the polygon column span fill block. A short directed run
// covers field extremes, every command and the corner cases; random polygons
// follow, mostly x-monotone with random vertical edges, some scrambled, with
// stray loads, restarts and unused commands mixed in. The vertex count is
// swept between phases while the block is idle. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import pcsf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int X_MAX         = (1 << X_W) - 1;
  localparam int Y_MAX         = (1 << Y_W) - 1;
  localparam int ITEM_TARGET   = 1650;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int POLYS_PER_CFG = 6;
  localparam logic [VCOUNT_W-1:0] VCOUNT_SWEEP [8] = '{3, 16, 31, 0, 5, 1, 17, 2};

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [VCOUNT_W-1:0] cfg_wr_data;
  int                  fail_count;
  int                  spans_pending;
  int                  send_idle_pct = 26;
  int                  recv_idle_pct = 51;
  int                  items_sent    = 0;
  int                  cycle_count   = 0;
  logic [VCOUNT_W-1:0] vcount_now    = VCOUNT_W'(VCOUNT_RESET);

  pcsf_cmd_if  cmd ();
  pcsf_span_if span ();

  polygon_column_span_fill_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .span        (span)
  );

  pcsf_span_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd           (cmd),
    .span          (span),
    .fail_count    (fail_count),
    .spans_pending (spans_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Span receiver with random stalls
  initial begin
    span.ready = 1'b0;
    forever begin
      @(posedge clk);
      span.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // One command transaction; returns at the edge that accepts it
  task automatic send_item(input mode_t m, input int idx, input int x, input int y);
    logic took;
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle_pct = 26;
      recv_idle_pct = 51;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 51;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.mode         <= m;
    cmd.vertex_index <= VIDX_W'(idx);
    cmd.vertex_x     <= X_W'(x);
    cmd.vertex_y     <= Y_W'(y);
    do begin
      @(negedge clk);
      took = cmd.ready;
      @(posedge clk);
    end while (!took);
    if (m != mode_t'(MODE_UNUSED)) items_sent++;
  endtask

  // Hold off until every span has arrived, then let the block settle
  task automatic wait_for_spans();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (spans_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VCOUNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    vcount_now = v;
  endtask

  // Load one polygon, start it and step through its columns
  task automatic run_polygon();
    int cnt, span_w, x0, rot, nexts, roll, p, tmp;
    int xs [MAX_VERTICES_DEF];
    int poly [MAX_VERTICES_DEF];
    bit upper [MAX_VERTICES_DEF];
    bit scrambled;
    cnt = vcount_now;
    if (cnt < MIN_VERTICES) cnt = MIN_VERTICES;
    if (cnt > MAX_VERTICES_DEF) cnt = MAX_VERTICES_DEF;

    // x extent: mostly narrow, now and then wide or full screen
    roll = $urandom_range(0, 99);
    if (roll < 4) span_w = 0;
    else if (roll < 80) span_w = $urandom_range(1, 16);
    else if (roll < 95) span_w = $urandom_range(17, 120);
    else span_w = X_MAX;
    roll = $urandom_range(0, 9);
    if (roll == 0) x0 = 0;
    else if (roll == 1) x0 = X_MAX - span_w;
    else x0 = $urandom_range(0, X_MAX - span_w);
    scrambled = ($urandom_range(0, 9) == 0);

    for (int i = 0; i < cnt; i++) begin
      xs[i]    = x0 + $urandom_range(0, span_w);
      upper[i] = $urandom_range(0, 1);
    end
    xs[0] = x0;
    xs[1] = x0 + span_w;

    if (scrambled) begin
      for (int i = 0; i < cnt; i++) poly[i] = xs[i];
    end else begin
      // sort, then lower chain left to right and upper chain back
      for (int i = 1; i < cnt; i++) begin
        for (int j = i; j > 0 && xs[j-1] > xs[j]; j--) begin
          tmp     = xs[j];
          xs[j]   = xs[j-1];
          xs[j-1] = tmp;
        end
      end
      p = 0;
      poly[p++] = xs[0];
      for (int i = 1; i < cnt - 1; i++) if (!upper[i]) poly[p++] = xs[i];
      poly[p++] = xs[cnt-1];
      for (int i = cnt - 2; i >= 1; i--) if (upper[i]) poly[p++] = xs[i];
    end

    // loads, rotated so the leftmost vertex lands anywhere
    rot = $urandom_range(0, cnt - 1);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(mode_t'(MODE_UNUSED), $urandom_range(0, 15), $urandom_range(0, X_MAX),
                  $urandom_range(0, Y_MAX));
      send_item(MODE_LOAD, (i + rot) % cnt, poly[i], $urandom_range(0, Y_MAX));
    end
    send_item(MODE_START, $urandom_range(0, 15), $urandom_range(0, X_MAX),
              $urandom_range(0, Y_MAX));

    if (span_w > 120) nexts = $urandom_range(5, 30);
    else if ($urandom_range(0, 7) == 0) nexts = $urandom_range(0, span_w);
    else nexts = span_w + $urandom_range(0, 2);

    // columns, with stray loads, unused commands and restarts mixed in
    for (int i = 0; i < nexts; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)
        send_item(MODE_LOAD, $urandom_range(0, 15), $urandom_range(0, X_MAX),
                  $urandom_range(0, Y_MAX));
      else if (roll < 5)
        send_item(mode_t'(MODE_UNUSED), $urandom_range(0, 15), $urandom_range(0, X_MAX),
                  $urandom_range(0, Y_MAX));
      else if (roll < 7)
        send_item(MODE_START, $urandom_range(0, 15), $urandom_range(0, X_MAX),
                  $urandom_range(0, Y_MAX));
      send_item(MODE_NEXT, $urandom_range(0, 15), $urandom_range(0, X_MAX),
                $urandom_range(0, Y_MAX));
    end
  endtask

  // Main sequence
  initial begin
    int seg;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    cmd.valid        = 1'b0;
    cmd.mode         = MODE_LOAD;
    cmd.vertex_index = '0;
    cmd.vertex_x     = '0;
    cmd.vertex_y     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle next, unused command at field maxima
    send_item(MODE_NEXT, 0, 0, 0);
    send_item(mode_t'(MODE_UNUSED), 15, X_MAX, Y_MAX);

    // Hexagon with a vertical edge at each end and the least x held twice
    send_item(MODE_LOAD, 0, 4, 100);
    send_item(MODE_LOAD, 1, 6, 0);
    send_item(MODE_LOAD, 2, 9, Y_MAX);
    send_item(MODE_LOAD, 3, 9, 500);
    send_item(MODE_LOAD, 4, 7, Y_MAX);
    send_item(MODE_LOAD, 5, 4, 300);
    // rest of the table at the coordinate extremes
    for (int i = 6; i < MAX_VERTICES_DEF; i++)
      send_item(MODE_LOAD, i, (i % 2) ? 0 : X_MAX, (i % 2) ? Y_MAX : 0);

    // five columns, then one next after the fill is done
    send_item(MODE_START, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_item(MODE_NEXT, 0, 0, 0);

    // Random polygons, vertex count swept between groups
    seg = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_for_spans();
      write_vertex_count((seg < 8) ? VCOUNT_SWEEP[seg] : VCOUNT_W'($urandom_range(0, 31)));
      seg++;
      for (int i = 0; i < POLYS_PER_CFG && items_sent < ITEM_TARGET; i++) run_polygon();
    end

    wait_for_spans();
    if (fail_count == 0 && spans_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pcsf_pkg.sv
rtl/pcsf_if.sv
rtl/polygon_column_span_fill_top.sv
verif/pcsf_span_checker.sv
verif/tb_top.sv
